[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH         = 16;
    localparam int PRIORITY_BITS = 16;
    localparam int HANDLE_BITS   = 16;
    localparam int COUNT_W       = $clog2(DEPTH + 1);

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [PRIORITY_BITS-1:0] priority_req;
        logic [HANDLE_BITS-1:0]   handle;
    } item_t;

    typedef struct packed {
        logic                     deq_valid;
        logic [HANDLE_BITS-1:0]   deq_handle;
        logic [PRIORITY_BITS-1:0] deq_priority;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        logic                     enq_dropped;
    } result_t;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [HANDLE_BITS-1:0]   handle;
    } entry_t;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t data;
    } op_t;

endpackage

[hw/rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds, takes the new entry or shifts.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic   clk,
    input  op_t    op,
    input  logic   occupied,
    input  logic   left_keep,
    input  entry_t left_entry,
    input  entry_t right_entry,
    output entry_t entry,
    output logic   keep
);

    entry_t entry_reg;
    entry_t entry_next;

    // entry stays ahead of an equal or lower new priority
    assign keep  = occupied && (entry_reg.prio >= op.data.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.enq)
        begin
            if (keep)
            begin
                entry_next = entry_reg;
            end
            else if (left_keep)
            begin
                entry_next = op.data;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
        else if (op.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[hw/rtl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a chain of cells, highest first.
// ----------------------------------------------------------------------------
// result: the result of an item is registered and presented in the cycle after its transfer
// throughput: one enqueue or dequeue per cycle unless the result is stalled;
//   every cell of the chain does its compare-and-shift step in parallel
// reset: entry count and result valid clear; stored entries are not cleared
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               result_valid_reg;
    result_t            result_reg;
    result_t            result_next;

    logic   accept;
    logic   full;
    logic   empty;
    op_t    op;
    entry_t cell_entry [DEPTH];
    logic   cell_keep  [DEPTH];

    assign item_stall   = result_valid_reg && result_stall;
    assign accept       = item_valid && !item_stall;
    assign full         = (count_reg == COUNT_W'(DEPTH));
    assign empty        = (count_reg == '0);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        op.enq          = accept && (item.mode == MODE_ENQ) && !full;
        op.deq          = accept && (item.mode == MODE_DEQ) && !empty;
        op.data.prio    = item.priority_req;
        op.data.handle  = item.handle;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic   occupied;
        logic   left_keep;
        entry_t left_entry;
        entry_t right_entry;

        assign occupied = (COUNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            // nothing ahead of the head slot
            assign left_keep  = 1'b1;
            assign left_entry = op.data;
        end
        else
        begin : g_body
            assign left_keep  = cell_keep[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .op          (op),
            .occupied    (occupied),
            .left_keep   (left_keep),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (op.enq)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (op.deq)
        begin
            count_next = count_reg - COUNT_W'(1);
        end

        result_next              = '0;
        result_next.entry_count  = count_next;
        result_next.is_empty     = (count_next == '0);
        if (item.mode == MODE_ENQ)
        begin
            result_next.enq_dropped = full;
        end
        else if (!empty)
        begin
            result_next.deq_valid    = 1'b1;
            result_next.deq_handle   = cell_entry[0].handle;
            result_next.deq_priority = cell_entry[0].prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the result register, loaded on each item transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule
